FILE: rtl/grid_ray_march_caster_defines.svh
// assertion macros for the grid ray march caster
// used by the top level only; SYNTH strips the checks
`ifndef GRID_RAY_MARCH_CASTER_DEFINES_SVH
`define GRID_RAY_MARCH_CASTER_DEFINES_SVH

`ifndef SYNTH
`define GRMC_ASSERT_HOLDS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("grmc check failed");
`define GRMC_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grmc check failed");
`else
`define GRMC_ASSERT_HOLDS(lbl, expr)
`define GRMC_ASSERT_IMPLIES(lbl, ante, cons)
`endif

`endif

FILE: rtl/grmc_pkg.sv
// shared types, constants and elaboration-time tables of the grid ray march caster
// no dependencies
package grmc_pkg;

    localparam int MAP_SIDE      = 16;
    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 320;
    localparam int MAX_STEPS     = 400;
    localparam int TRIG_ENTRIES  = 1024;

    localparam int HALF_FOV   = 5461;
    localparam int FOV_TURN   = 10923;
    localparam int HALF_COLS  = SCREEN_WIDTH / 2;
    localparam int STEP_DEN   = 80;
    localparam int CELL_DEN   = 327680;
    localparam int CELL_SHIFT = 16;
    localparam int CELL_FRAC  = CELL_DEN / (2 ** CELL_SHIFT);
    localparam logic [7:0] EMPTY_CODE = 8'h20;

    localparam int MAP_CELLS  = MAP_SIDE * MAP_SIDE;
    localparam int CELL_BITS  = $clog2(MAP_SIDE);
    localparam int MAP_AW     = 2 * CELL_BITS;
    localparam int TRIG_BITS  = $clog2(TRIG_ENTRIES);
    localparam int STEP_BITS  = $clog2(MAX_STEPS + 1);
    localparam int POS_MAX    = 65535 * STEP_DEN + MAX_STEPS * 16384;
    localparam int POS_BITS   = $clog2(POS_MAX + 1) + 1;
    localparam int POS_LIMIT  = MAP_SIDE * CELL_DEN;
    localparam int HI_BITS    = $clog2(MAP_SIDE * CELL_FRAC);
    localparam int DEN_BITS   = STEP_BITS + 15;
    localparam longint NUM_VAL = longint'(SCREEN_HEIGHT) * longint'(CELL_DEN);
    localparam int NUM_BITS   = $clog2(NUM_VAL + 1);
    localparam int DCNT_BITS  = $clog2(NUM_BITS);

    typedef enum logic [1:0] {
        CFG_PLAYER_X   = 2'd0,
        CFG_PLAYER_Y   = 2'd1,
        CFG_VIEW_ANGLE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        TRIG_COS_ANGLE,
        TRIG_SIN_ANGLE,
        TRIG_COS_OFFSET
    } trig_sel_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] cell_index;
        logic [7:0] cell_code;
        logic [6:0] ray_column;
    } in_item_t;

    typedef struct packed {
        logic [6:0] column_out;
        logic       wall_hit;
        logic [7:0] wall_code;
        logic [8:0] wall_height;
        logic [8:0] march_count;
    } out_item_t;

    typedef struct packed {
        logic      start;
        trig_sel_t trig_sel;
        logic      cap_cs;
        logic      cap_sn;
        logic      cap_cd;
        logic      step;
        logic      latch_end;
        logic      mul;
        logic      div_step;
    } dp_cmd_t;

    typedef struct packed {
        logic term;
        logic hit;
        logic div_last;
    } dp_status_t;

    typedef logic signed [15:0] sine_rom_t [TRIG_ENTRIES];
    typedef logic [15:0] offset_rom_t [128];
    typedef logic [CELL_BITS-1:0] div5_rom_t [2 ** HI_BITS];

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    function automatic logic signed [15:0] sine_of_phase(logic [31:0] ph);
        longint unsigned f, x, x2, t, s, q;
        f = longint'(ph[29:0]);
        if (ph[30])
            f = Q30_ONE - f;
        x  = (f * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - ((x2 * Q30_ONE) >> 30) / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        q  = (s + 64'd32768) >> 16;
        if (q > 64'd16384)
            q = 64'd16384;
        return ph[31] ? -$signed(16'(q)) : $signed(16'(q));
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k < TRIG_ENTRIES; k++)
            rom[k] = sine_of_phase(32'((longint'(k) << 32) / TRIG_ENTRIES));
        return rom;
    endfunction

    function automatic offset_rom_t build_offset_rom();
        offset_rom_t rom;
        for (int c = 0; c < 128; c++)
            rom[c] = 16'(65536 - HALF_FOV + (FOV_TURN * c) / HALF_COLS);
        return rom;
    endfunction

    function automatic div5_rom_t build_div5_rom();
        div5_rom_t rom;
        for (int i = 0; i < 2 ** HI_BITS; i++)
            rom[i] = CELL_BITS'(i / CELL_FRAC);
        return rom;
    endfunction

    // table index of a turn fraction
    function automatic logic [TRIG_BITS-1:0] trig_index(logic [15:0] a);
        logic [31:0] p;
        p = 32'(a) * 32'(TRIG_ENTRIES);
        return p[16 +: TRIG_BITS];
    endfunction

endpackage

FILE: rtl/grmc_ctrl.sv
// sequencer of the grid ray march caster: trig fetch, march, divide, hand-off
// depends on grmc_pkg
module grmc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cast_accept,
    input  logic                 out_room,
    input  grmc_pkg::dp_status_t status,
    output grmc_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 load_out
);
    import grmc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRIG_A,
        S_TRIG_B,
        S_TRIG_C,
        S_TRIG_D,
        S_MARCH,
        S_MULT,
        S_DIVIDE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.trig_sel = TRIG_COS_ANGLE;
        state_next = state_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.start = cast_accept;
                if (cast_accept)
                    state_next = S_TRIG_A;
            end
            S_TRIG_A:
            begin
                cmd.trig_sel = TRIG_COS_ANGLE;
                state_next   = S_TRIG_B;
            end
            S_TRIG_B:
            begin
                cmd.trig_sel = TRIG_SIN_ANGLE;
                cmd.cap_cs   = 1'b1;
                state_next   = S_TRIG_C;
            end
            S_TRIG_C:
            begin
                cmd.trig_sel = TRIG_COS_OFFSET;
                cmd.cap_sn   = 1'b1;
                state_next   = S_TRIG_D;
            end
            S_TRIG_D:
            begin
                cmd.cap_cd = 1'b1;
                state_next = S_MARCH;
            end
            S_MARCH:
            begin
                cmd.step      = 1'b1;
                cmd.latch_end = status.term;
                if (status.term)
                    state_next = status.hit ? S_MULT : S_DONE;
            end
            S_MULT:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                load_out = out_room;
                if (out_room)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: rtl/grmc_datapath.sv
// datapath of the grid ray march caster: config, map memory, sine rom,
// march stepper with one map read per cycle, multiplier and restoring divider
// depends on grmc_pkg
module grmc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 map_we,
    input  grmc_pkg::in_item_t   in_data,
    input  grmc_pkg::dp_cmd_t    cmd,
    output grmc_pkg::dp_status_t status,
    output grmc_pkg::out_item_t  result
);
    import grmc_pkg::*;

    localparam sine_rom_t   SINE_ROM   = build_sine_rom();
    localparam offset_rom_t OFFSET_ROM = build_offset_rom();
    localparam div5_rom_t   DIV5_ROM   = build_div5_rom();

    logic [15:0] player_x_reg;
    logic [15:0] player_y_reg;
    logic [15:0] view_angle_reg;

    logic [6:0]  col_reg;
    logic [15:0] offset_reg;
    logic [15:0] angle_reg;
    logic [TRIG_BITS-1:0] rom_addr;
    logic signed [15:0] rom_q_reg;
    logic signed [15:0] cs_reg;
    logic signed [15:0] sn_reg;
    logic [14:0] cd_pos_reg;

    logic [7:0] map_mem [MAP_CELLS];
    logic [7:0] map_q_reg;

    logic signed [POS_BITS-1:0] nx_reg;
    logic signed [POS_BITS-1:0] ny_reg;
    logic [STEP_BITS-1:0] ni_reg;
    logic oob;
    logic exh;
    logic [CELL_BITS-1:0] gx;
    logic [CELL_BITS-1:0] gy;
    logic [MAP_AW-1:0] rd_addr;

    logic rd_valid_reg;
    logic [STEP_BITS-1:0] rd_n_reg;
    logic rd_oob_reg;
    logic rd_exh_reg;
    logic wall;

    logic hit_reg;
    logic [7:0] code_reg;
    logic [STEP_BITS-1:0] count_reg;

    logic [DEN_BITS-1:0] den_reg;
    logic [DEN_BITS-1:0] rem_reg;
    logic [NUM_BITS-1:0] quo_reg;
    logic [DCNT_BITS-1:0] div_cnt_reg;
    logic [DEN_BITS:0] rem_shift;
    logic rem_ge;
    logic [8:0] height;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_x_reg   <= '0;
            player_y_reg   <= '0;
            view_angle_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PLAYER_X:   player_x_reg   <= cfg_data;
                CFG_PLAYER_Y:   player_y_reg   <= cfg_data;
                CFG_VIEW_ANGLE: view_angle_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // ray setup and trig fetch
    always_comb
    begin
        case (cmd.trig_sel)
            TRIG_COS_ANGLE:  rom_addr = trig_index(angle_reg + 16'd16384);
            TRIG_SIN_ANGLE:  rom_addr = trig_index(angle_reg);
            TRIG_COS_OFFSET: rom_addr = trig_index(offset_reg + 16'd16384);
            default:         rom_addr = trig_index(angle_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        rom_q_reg <= SINE_ROM[rom_addr];
        if (cmd.start)
        begin
            col_reg    <= in_data.ray_column;
            offset_reg <= OFFSET_ROM[in_data.ray_column];
            angle_reg  <= view_angle_reg + OFFSET_ROM[in_data.ray_column];
        end
        if (cmd.cap_cs)
            cs_reg <= rom_q_reg;
        if (cmd.cap_sn)
            sn_reg <= rom_q_reg;
        if (cmd.cap_cd)
            cd_pos_reg <= (rom_q_reg > 16'sd0) ? rom_q_reg[14:0] : 15'd0;
    end

    // map memory, written by map items and read once per march step
    always_ff @(posedge clk)
    begin
        if (map_we && (32'(in_data.cell_index) < 32'(MAP_CELLS)))
            map_mem[MAP_AW'(in_data.cell_index)] <= in_data.cell_code;
        if (cmd.step)
            map_q_reg <= map_mem[rd_addr];
    end

    // step issue: cell of the current position
    always_comb
    begin
        oob = nx_reg[POS_BITS-1] || ny_reg[POS_BITS-1]
            || (nx_reg >= POS_BITS'(POS_LIMIT)) || (ny_reg >= POS_BITS'(POS_LIMIT));
        exh = (ni_reg == STEP_BITS'(MAX_STEPS));
        gx  = DIV5_ROM[nx_reg[CELL_SHIFT +: HI_BITS]];
        gy  = DIV5_ROM[ny_reg[CELL_SHIFT +: HI_BITS]];
        rd_addr = {gy, gx};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_cd)
        begin
            nx_reg <= POS_BITS'(player_x_reg * 7'(STEP_DEN));
            ny_reg <= POS_BITS'(player_y_reg * 7'(STEP_DEN));
            ni_reg <= '0;
        end
        else if (cmd.step)
        begin
            nx_reg <= nx_reg + POS_BITS'(cs_reg);
            ny_reg <= ny_reg + POS_BITS'(sn_reg);
            ni_reg <= ni_reg + 1'b1;
        end
        if (cmd.step)
        begin
            rd_n_reg   <= ni_reg;
            rd_oob_reg <= oob;
            rd_exh_reg <= exh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= cmd.step;
    end

    // the range limit is checked before the map, leaving the map before the cell
    assign wall = (map_q_reg != EMPTY_CODE);
    assign status.term = rd_valid_reg && (rd_exh_reg || rd_oob_reg || wall);
    assign status.hit  = !rd_exh_reg && !rd_oob_reg && wall;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_end)
        begin
            hit_reg   <= status.hit;
            code_reg  <= status.hit ? map_q_reg : EMPTY_CODE;
            count_reg <= rd_exh_reg ? STEP_BITS'(MAX_STEPS) : rd_n_reg;
        end
    end

    // height = SCREEN_HEIGHT*CELL_DEN / (n*cos), one quotient bit a cycle;
    // a zero divisor gives all ones, which saturates like any large quotient
    assign rem_shift = {rem_reg, quo_reg[NUM_BITS-1]};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            den_reg <= DEN_BITS'(count_reg * cd_pos_reg);
            rem_reg <= '0;
            quo_reg <= NUM_BITS'(NUM_VAL);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? DEN_BITS'(rem_shift - {1'b0, den_reg})
                              : DEN_BITS'(rem_shift);
            quo_reg <= {quo_reg[NUM_BITS-2:0], rem_ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.mul)
            div_cnt_reg <= '0;
        else if (cmd.div_step)
            div_cnt_reg <= div_cnt_reg + 1'b1;
    end

    assign status.div_last = (div_cnt_reg == DCNT_BITS'(NUM_BITS - 1));

    always_comb
    begin
        if (!hit_reg)
            height = '0;
        else if (quo_reg > NUM_BITS'(SCREEN_HEIGHT))
            height = 9'(SCREEN_HEIGHT);
        else
            height = 9'(quo_reg);
    end

    assign result.column_out  = col_reg;
    assign result.wall_hit    = hit_reg;
    assign result.wall_code   = code_reg;
    assign result.wall_height = height;
    assign result.march_count = 9'(count_reg);

endmodule

FILE: rtl/grid_ray_march_caster.sv
// grid ray march caster: 16x16 cell map, one ray cast per cast item
// top level; depends on grmc_pkg, grmc_ctrl, grmc_datapath and the defines header
//
// input channel (in_valid, in_stall, in_data): a map item (req_type 0) stores
// one cell byte and is taken without raising in_stall, with no result. a cast
// item (req_type 1) marches one ray and yields one result item on the output
// channel (out_valid, out_stall, out_data).
// a cast reads the sine table for the ray angle and column offset, then
// marches (one map read per step, up to 400 steps), then for a hit runs a
// multiply and the bit-serial divide, and ends with the hand-off; the next
// item is taken in the cycle after the hand-off. the march loop and the
// bit-serial divider take the bulk of a cast.
// in_stall stays high while a cast is in flight; a finished result sits in
// the output register, so a new item is taken while it waits there. if the
// receiver stalls with a result still held, the next cast stops at its end
// until that register frees. config (cfg_we, cfg_index, cfg_data) must be
// written only while idle; the block itself does not enforce it. reset clears
// config to zero and empties the output; the map is undefined until written.
`include "grid_ray_march_caster_defines.svh"

module grid_ray_march_caster (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  grmc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output grmc_pkg::out_item_t out_data
);
    import grmc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    out_item_t  result;
    out_item_t  out_data_reg;
    logic       out_valid_reg;
    logic       busy;
    logic       load_out;
    logic       out_room;
    logic       in_take;

    assign in_take  = in_valid && !busy;
    assign out_room = !out_valid_reg || !out_stall;

    grmc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cast_accept (in_take && in_data.req_type),
        .out_room    (out_room),
        .status      (status),
        .cmd         (cmd),
        .busy        (busy),
        .load_out    (load_out)
    );

    grmc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .map_we    (in_take && !in_data.req_type),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_data_reg <= result;
    end

    assign in_stall  = busy;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `GRMC_ASSERT_IMPLIES(a_load_has_room, load_out, !out_valid_reg || !out_stall)
    `GRMC_ASSERT_IMPLIES(a_miss_is_empty, out_valid_reg && !out_data_reg.wall_hit, out_data_reg.wall_height == 9'd0 && out_data_reg.wall_code == EMPTY_CODE)
    `GRMC_ASSERT_IMPLIES(a_hit_height_range, out_valid_reg && out_data_reg.wall_hit, out_data_reg.wall_height <= 9'(SCREEN_HEIGHT) && out_data_reg.wall_code != EMPTY_CODE)
    `GRMC_ASSERT_HOLDS(a_load_only_when_busy, !load_out || busy)

endmodule
